// ===== hdl/i2c_mbe_pkg.sv =====
// Package: phase codes, command kinds, register indexes and reset values of the I2C byte engine.
package i2c_mbe_pkg;

  typedef enum logic [15:0] {
    PH_IDLE = 16'h0001,
    PH_ST1  = 16'h0002,
    PH_ST2  = 16'h0004,
    PH_SP1  = 16'h0008,
    PH_SP2  = 16'h0010,
    PH_SP3  = 16'h0020,
    PH_WLO  = 16'h0040,
    PH_WHI  = 16'h0080,
    PH_WTL  = 16'h0100,
    PH_AK1  = 16'h0200,
    PH_AK2  = 16'h0400,
    PH_AKP  = 16'h0800,
    PH_RLO  = 16'h1000,
    PH_RHI  = 16'h2000,
    PH_RA1  = 16'h4000,
    PH_RA2  = 16'h8000
  } phase_t;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_STOP  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SETUP_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_TICKS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TICKS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 2'd3;

  localparam logic [15:0] SETUP_TICKS_RST = 16'd4;
  localparam logic [15:0] BIT_TICKS_RST   = 16'd2;
  localparam logic [15:0] ACK_TICKS_RST   = 16'd1;
  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;

  localparam int unsigned BYTE_BITS = 8;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rd_data;
    logic       ack_error;
  } res_t;

endpackage

// ===== hdl/i2c_mbe_ifs.sv =====
// Interfaces: tick/command channel and result channel of the I2C byte engine.
interface i2c_mbe_cmd_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [1:0] kind;
  logic [7:0] wr_data;
  logic       send_ack;
  logic       sda_in;

  modport source (output valid, cmd_valid, kind, wr_data, send_ack, sda_in, input ready);
  modport sink   (input valid, cmd_valid, kind, wr_data, send_ack, sda_in, output ready);
endinterface

interface i2c_mbe_res_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rd_data;
  logic       ack_error;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, rd_data, ack_error,
                  input ready);
  modport sink   (input valid, scl_out, sda_out, busy_res, done_res, rd_data, ack_error,
                  output ready);
endinterface

// ===== hdl/i2c_master_byte_engine_unit.sv =====
// I2C master byte engine: one transaction on the cmd channel is one timing tick; each tick
// updates the phase sequencer and yields one result transaction with the SCL/SDA levels,
// busy, done, read byte and ack-error flag. Throughput is one tick per clock while results are
// drained; each result enters the output register in the cycle after its tick is accepted, and
// a new tick is taken when that register is empty or being drained. Phase lengths come from
// the setup/bit/ack tick registers (0 acts as 1); write them only while the engine is idle.
module i2c_master_byte_engine_unit
  import i2c_mbe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  i2c_mbe_cmd_if.sink          cmd,
  i2c_mbe_res_if.source        res
);

  logic [15:0] setup_ticks, bit_ticks, ack_ticks;
  logic [7:0]  ack_timeout;

  phase_t      phase, phase_next;
  logic [15:0] tick_count, tick_count_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [7:0]  poll_count, poll_count_next;
  logic        scl_level, scl_level_next;
  logic        sda_level, sda_level_next;
  logic        error_flag, error_flag_next;
  logic        ack_choice, ack_choice_next;
  logic [7:0]  last_read, last_read_next;
  logic        done_next;

  logic        res_valid;
  res_t        res_data;
  logic        accept;
  logic [15:0] len_raw, phase_len;
  logic [3:0]  bit_inc;
  logic [8:0]  poll_inc;

  assign cmd.ready = !res_valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      setup_ticks <= SETUP_TICKS_RST;
      bit_ticks   <= BIT_TICKS_RST;
      ack_ticks   <= ACK_TICKS_RST;
      ack_timeout <= ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SETUP_TICKS: setup_ticks <= cfg_data;
        CFG_BIT_TICKS:   bit_ticks   <= cfg_data;
        CFG_ACK_TICKS:   ack_ticks   <= cfg_data;
        CFG_ACK_TIMEOUT: ack_timeout <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (phase)
      PH_ST1, PH_ST2, PH_SP1, PH_SP2, PH_SP3: len_raw = setup_ticks;
      PH_AK1, PH_AK2:                         len_raw = ack_ticks;
      default:                                len_raw = bit_ticks;
    endcase
    phase_len = (len_raw == 16'd0) ? 16'd1 : len_raw;
  end

  assign bit_inc  = bit_index + 4'd1;

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    bit_index_next  = bit_index;
    shift_byte_next = shift_byte;
    poll_count_next = poll_count;
    scl_level_next  = scl_level;
    sda_level_next  = sda_level;
    error_flag_next = error_flag;
    ack_choice_next = ack_choice;
    last_read_next  = last_read;
    done_next       = 1'b0;
    poll_inc        = {1'b0, poll_count} + 9'd1;

    if (phase == PH_IDLE) begin
      if (cmd.cmd_valid) begin
        tick_count_next = 16'd1;
        case (cmd.kind)
          KIND_START: begin
            phase_next = PH_ST1; scl_level_next = 1'b1; sda_level_next = 1'b1;
          end
          KIND_STOP: begin
            phase_next = PH_SP1; scl_level_next = 1'b0; sda_level_next = 1'b0;
          end
          KIND_WRITE: begin
            shift_byte_next = cmd.wr_data;
            bit_index_next  = 4'd0;
            error_flag_next = 1'b0;
            phase_next      = PH_WLO;
            scl_level_next  = 1'b0;
            sda_level_next  = cmd.wr_data[7];
          end
          default: begin
            shift_byte_next = 8'd0;
            bit_index_next  = 4'd0;
            ack_choice_next = cmd.send_ack;
            phase_next      = PH_RLO;
            scl_level_next  = 1'b0;
            sda_level_next  = 1'b1;
          end
        endcase
      end
    end else if (phase != PH_AKP && tick_count < phase_len) begin
      tick_count_next = tick_count + 16'd1;
    end else begin
      tick_count_next = 16'd1;
      // AK2 moves into polling and takes its first poll on the same tick
      if (phase == PH_AK2) begin
        poll_inc = 9'd1;
      end
      case (phase)
        PH_ST1: begin phase_next = PH_ST2; scl_level_next = 1'b1; sda_level_next = 1'b0; end
        PH_ST2: begin phase_next = PH_IDLE; scl_level_next = 1'b0; sda_level_next = 1'b0; end
        PH_SP1: begin phase_next = PH_SP2; scl_level_next = 1'b1; sda_level_next = 1'b0; end
        PH_SP2: begin phase_next = PH_SP3; scl_level_next = 1'b1; sda_level_next = 1'b1; end
        PH_SP3: begin phase_next = PH_IDLE; scl_level_next = 1'b1; sda_level_next = 1'b1; end
        PH_WLO: begin phase_next = PH_WHI; scl_level_next = 1'b1; end
        PH_WHI: begin phase_next = PH_WTL; scl_level_next = 1'b0; end
        PH_WTL: begin
          bit_index_next = bit_inc;
          scl_level_next = 1'b0;
          if (bit_inc < 4'(BYTE_BITS)) begin
            shift_byte_next = {shift_byte[6:0], 1'b0};
            phase_next      = PH_WLO;
            sda_level_next  = shift_byte[6];
          end else begin
            phase_next     = PH_AK1;
            sda_level_next = 1'b1;
          end
        end
        PH_AK1: begin phase_next = PH_AK2; scl_level_next = 1'b1; sda_level_next = 1'b1; end
        PH_AK2, PH_AKP: begin
          phase_next      = PH_AKP;
          scl_level_next  = 1'b1;
          sda_level_next  = 1'b1;
          poll_count_next = (phase == PH_AK2) ? 8'd0 : poll_count;
          if (!cmd.sda_in) begin
            phase_next     = PH_IDLE;
            scl_level_next = 1'b0;
            sda_level_next = 1'b1;
          end else if (poll_inc > {1'b0, ack_timeout}) begin
            error_flag_next = 1'b1;
            phase_next      = PH_SP1;
            scl_level_next  = 1'b0;
            sda_level_next  = 1'b0;
          end else begin
            poll_count_next = poll_inc[7:0];
          end
        end
        PH_RLO: begin
          phase_next      = PH_RHI;
          scl_level_next  = 1'b1;
          sda_level_next  = 1'b1;
          shift_byte_next = {shift_byte[6:0], cmd.sda_in};
        end
        PH_RHI: begin
          bit_index_next = bit_inc;
          scl_level_next = 1'b0;
          if (bit_inc < 4'(BYTE_BITS)) begin
            phase_next     = PH_RLO;
            sda_level_next = 1'b1;
          end else begin
            phase_next     = PH_RA1;
            sda_level_next = !ack_choice;
          end
        end
        PH_RA1: begin phase_next = PH_RA2; scl_level_next = 1'b1; end
        PH_RA2: begin
          last_read_next = shift_byte;
          phase_next     = PH_IDLE;
          scl_level_next = 1'b0;
        end
        default: phase_next = PH_IDLE;
      endcase
      if (phase_next == PH_IDLE) begin
        tick_count_next = 16'd0;
        done_next       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= 16'd0;
      bit_index  <= 4'd0;
      shift_byte <= 8'd0;
      poll_count <= 8'd0;
      scl_level  <= 1'b1;
      sda_level  <= 1'b1;
      error_flag <= 1'b0;
      ack_choice <= 1'b0;
      last_read  <= 8'd0;
      res_valid  <= 1'b0;
    end else begin
      if (accept) begin
        phase      <= phase_next;
        tick_count <= tick_count_next;
        bit_index  <= bit_index_next;
        shift_byte <= shift_byte_next;
        poll_count <= poll_count_next;
        scl_level  <= scl_level_next;
        sda_level  <= sda_level_next;
        error_flag <= error_flag_next;
        ack_choice <= ack_choice_next;
        last_read  <= last_read_next;
        res_valid  <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_data.scl_out   <= scl_level_next;
      res_data.sda_out   <= sda_level_next;
      res_data.busy_res  <= (phase_next != PH_IDLE);
      res_data.done_res  <= done_next;
      res_data.rd_data   <= last_read_next;
      res_data.ack_error <= error_flag_next;
    end
  end

  assign res.valid     = res_valid;
  assign res.scl_out   = res_data.scl_out;
  assign res.sda_out   = res_data.sda_out;
  assign res.busy_res  = res_data.busy_res;
  assign res.done_res  = res_data.done_res;
  assign res.rd_data   = res_data.rd_data;
  assign res.ack_error = res_data.ack_error;

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.done_res |-> !res_data.busy_res)
    else $error("done with busy set");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_IDLE && !cmd.cmd_valid |=> phase == PH_IDLE)
    else $error("left idle without a command");

  a_tick_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase != PH_IDLE |-> tick_count != 16'd0)
    else $error("active phase with zero tick count");

  a_error_stop: assert property (@(posedge clk) disable iff (rst)
    $rose(error_flag) |-> phase == PH_SP1)
    else $error("ack error without stop");

  a_busy_matches: assert property (@(posedge clk) disable iff (rst)
    accept |=> res_data.busy_res == (phase != PH_IDLE))
    else $error("busy disagrees with phase");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the I2C master byte engine: directed commands, then random traffic.
module tb
  import i2c_mbe_pkg::*;
;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NEVER_ACK      = 300;

  typedef struct packed {
    logic       cv;
    logic [1:0] kind;
    logic [7:0] wr;
    logic       ack;
    logic       sda;
  } tick_t;

  typedef struct {
    bit         cv;
    logic [1:0] kind;
    logic [7:0] wr;
    bit         ack;
    logic [7:0] pat;
    int         highs;
    bit         noisy;
    bit         chk;
    res_t       want;
  } cmd_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  i2c_mbe_cmd_if cmd_ch ();
  i2c_mbe_res_if res_ch ();

  i2c_master_byte_engine_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch),
    .res       (res_ch)
  );

  always #5 clk = ~clk;

  // engine state mirror
  logic [15:0] r_setup, r_bit, r_ack;
  logic [7:0]  r_tmo;
  phase_t      ph;
  logic [15:0] tcnt;
  logic [3:0]  bidx;
  logic [7:0]  shreg, pcnt, rd_q;
  logic        scl_q, sda_q, err_q, ack_sel, done_q;

  res_t bus_results_q[$];
  int   tx_idle_pct, rx_idle_pct;
  int   ticks_sent;
  int   mismatches;
  int   idle_cycles;
  int   hold_left;
  bit   hold_req;
  logic [7:0] rd_pattern;
  int   ack_high_left;

  cmd_row_t dir_rows [14] = '{
    '{1'b0, KIND_START, 8'h00, 1'b0, 8'h00, 0, 1'b0, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
    '{1'b1, KIND_START, 8'h00, 1'b0, 8'h00, 0, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0}},
    '{1'b1, KIND_WRITE, 8'hFF, 1'b0, 8'h00, 0, 1'b0, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0}},
    '{1'b1, KIND_WRITE, 8'h00, 1'b0, 8'h00, 2, 1'b0, 1'b0, '0},
    '{1'b1, KIND_READ,  8'h00, 1'b1, 8'hA5, 0, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 8'hA5, 1'b0}},
    '{1'b1, KIND_READ,  8'h00, 1'b0, 8'h5A, 0, 1'b0, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 8'h5A, 1'b0}},
    '{1'b1, KIND_WRITE, 8'h3C, 1'b0, 8'h00, NEVER_ACK, 1'b0, 1'b1,
      '{1'b1, 1'b1, 1'b0, 1'b1, 8'h5A, 1'b1}},
    '{1'b1, KIND_START, 8'h00, 1'b0, 8'h00, 0, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 8'h5A, 1'b1}},
    '{1'b1, KIND_READ,  8'h00, 1'b1, 8'hFF, 0, 1'b1, 1'b0, '0},
    '{1'b1, KIND_WRITE, 8'h80, 1'b0, 8'h00, 0, 1'b0, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 8'hFF, 1'b0}},
    '{1'b1, KIND_READ,  8'h00, 1'b0, 8'h00, 0, 1'b0, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0}},
    '{1'b1, KIND_STOP,  8'h00, 1'b0, 8'h00, 0, 1'b0, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0}},
    '{1'b1, KIND_STOP,  8'h00, 1'b0, 8'h00, 0, 1'b1, 1'b0, '0},
    '{1'b1, KIND_WRITE, 8'h01, 1'b0, 8'h00, 1, 1'b1, 1'b0, '0}
  };

  function automatic void engine_reset();
    r_setup = SETUP_TICKS_RST;
    r_bit   = BIT_TICKS_RST;
    r_ack   = ACK_TICKS_RST;
    r_tmo   = ACK_TIMEOUT_RST;
    ph      = PH_IDLE;
    tcnt    = '0;
    bidx    = '0;
    shreg   = '0;
    pcnt    = '0;
    rd_q    = '0;
    scl_q   = 1'b1;
    sda_q   = 1'b1;
    err_q   = 1'b0;
    ack_sel = 1'b0;
    done_q  = 1'b0;
  endfunction

  function automatic void go(phase_t p, logic c, logic d);
    ph    = p;
    tcnt  = 16'd1;
    scl_q = c;
    sda_q = d;
  endfunction

  function automatic void wrap(logic c, logic d);
    ph     = PH_IDLE;
    tcnt   = '0;
    scl_q  = c;
    sda_q  = d;
    done_q = 1'b1;
  endfunction

  function automatic logic [15:0] phase_len();
    logic [15:0] n;
    case (ph)
      PH_ST1, PH_ST2, PH_SP1, PH_SP2, PH_SP3: n = r_setup;
      PH_AK1, PH_AK2: n = r_ack;
      default: n = r_bit;
    endcase
    return (n == 16'd0) ? 16'd1 : n;
  endfunction

  function automatic void poll_ack(logic s);
    if (!s) begin
      wrap(1'b0, 1'b1);
    end else if ({1'b0, pcnt} + 9'd1 > {1'b0, r_tmo}) begin
      err_q = 1'b1;
      go(PH_SP1, 1'b0, 1'b0);
    end else begin
      pcnt = pcnt + 8'd1;
    end
  endfunction

  function automatic void next_phase(logic s);
    case (ph)
      PH_ST1: go(PH_ST2, 1'b1, 1'b0);
      PH_ST2: wrap(1'b0, 1'b0);
      PH_SP1: go(PH_SP2, 1'b1, 1'b0);
      PH_SP2: go(PH_SP3, 1'b1, 1'b1);
      PH_SP3: wrap(1'b1, 1'b1);
      PH_WLO: go(PH_WHI, 1'b1, sda_q);
      PH_WHI: go(PH_WTL, 1'b0, sda_q);
      PH_WTL: begin
        bidx = bidx + 4'd1;
        if (bidx < 4'd8) begin
          shreg = shreg << 1;
          go(PH_WLO, 1'b0, shreg[7]);
        end else begin
          go(PH_AK1, 1'b0, 1'b1);
        end
      end
      PH_AK1: go(PH_AK2, 1'b1, 1'b1);
      PH_AK2: begin
        go(PH_AKP, 1'b1, 1'b1);
        pcnt = '0;
        poll_ack(s);
      end
      PH_RLO: begin
        go(PH_RHI, 1'b1, 1'b1);
        shreg = {shreg[6:0], s};
      end
      PH_RHI: begin
        bidx = bidx + 4'd1;
        if (bidx < 4'd8) go(PH_RLO, 1'b0, 1'b1);
        else go(PH_RA1, 1'b0, !ack_sel);
      end
      PH_RA1: go(PH_RA2, 1'b1, sda_q);
      PH_RA2: begin
        rd_q = shreg;
        wrap(1'b0, sda_q);
      end
      default: wrap(scl_q, sda_q);
    endcase
  endfunction

  function automatic res_t engine_tick(tick_t t);
    res_t r;
    done_q = 1'b0;
    if (ph == PH_IDLE) begin
      if (t.cv) begin
        case (t.kind)
          KIND_START: go(PH_ST1, 1'b1, 1'b1);
          KIND_STOP:  go(PH_SP1, 1'b0, 1'b0);
          KIND_WRITE: begin
            shreg = t.wr;
            bidx  = '0;
            err_q = 1'b0;
            go(PH_WLO, 1'b0, t.wr[7]);
          end
          default: begin
            shreg   = '0;
            bidx    = '0;
            ack_sel = t.ack;
            go(PH_RLO, 1'b0, 1'b1);
          end
        endcase
      end
    end else if (ph == PH_AKP) begin
      poll_ack(t.sda);
    end else if (tcnt < phase_len()) begin
      tcnt = tcnt + 16'd1;
    end else begin
      next_phase(t.sda);
    end
    r.scl_out   = scl_q;
    r.sda_out   = sda_q;
    r.busy_res  = (ph != PH_IDLE);
    r.done_res  = done_q;
    r.rd_data   = rd_q;
    r.ack_error = err_q;
    return r;
  endfunction

  // slave side of SDA: read data bits, then a count of high polls before the ACK
  function automatic logic line_level();
    if (ph == PH_RLO) return rd_pattern[3'd7 - bidx[2:0]];
    if (ph == PH_AK2 || ph == PH_AKP) begin
      if (ack_high_left > 0) begin
        ack_high_left--;
        return 1'b1;
      end
      return 1'b0;
    end
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic report(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic cmp(string what, logic [7:0] got, logic [7:0] want);
    if (got !== want) report(what, got, want);
  endtask

  task automatic check_result();
    res_t w;
    if (bus_results_q.size() == 0) begin
      report("unexpected result transaction", res_ch.rd_data, 8'h00);
      return;
    end
    w = bus_results_q.pop_front();
    cmp("scl_out", res_ch.scl_out, w.scl_out);
    cmp("sda_out", res_ch.sda_out, w.sda_out);
    cmp("busy_res", res_ch.busy_res, w.busy_res);
    cmp("done_res", res_ch.done_res, w.done_res);
    cmp("rd_data", res_ch.rd_data, w.rd_data);
    cmp("ack_error", res_ch.ack_error, w.ack_error);
  endtask

  task automatic issue_tick(tick_t t, bit pin_on, res_t pin);
    res_t r;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.cmd_valid <= t.cv;
    cmd_ch.kind      <= t.kind;
    cmd_ch.wr_data   <= t.wr;
    cmd_ch.send_ack  <= t.ack;
    cmd_ch.sda_in    <= t.sda;
    do @(posedge clk); while (!cmd_ch.ready);
    r = engine_tick(t);
    if (pin_on && !r.busy_res) r = pin;
    bus_results_q.push_back(r);
    ticks_sent++;
  endtask

  task automatic run_cmd(cmd_row_t c);
    tick_t t;
    rd_pattern    = c.pat;
    ack_high_left = c.highs;
    t.cv   = c.cv;
    t.kind = c.kind;
    t.wr   = c.wr;
    t.ack  = c.ack;
    t.sda  = line_level();
    issue_tick(t, c.chk, c.want);
    while (ph != PH_IDLE) begin
      t.cv   = c.noisy ? 1'($urandom_range(0, 1)) : 1'b0;
      t.kind = 2'($urandom_range(0, 3));
      t.wr   = 8'($urandom);
      t.ack  = 1'($urandom_range(0, 1));
      t.sda  = line_level();
      issue_tick(t, c.chk, c.want);
    end
  endtask

  function automatic cmd_row_t rand_row(bit cv, logic [1:0] k);
    cmd_row_t c;
    c.cv    = cv;
    c.kind  = k;
    c.wr    = 8'($urandom);
    c.ack   = 1'($urandom_range(0, 1));
    c.pat   = 8'($urandom);
    c.highs = ($urandom_range(0, 5) == 0) ? NEVER_ACK : $urandom_range(0, 3);
    c.noisy = ($urandom_range(0, 3) == 0);
    c.chk   = 1'b0;
    c.want  = '0;
    return c;
  endfunction

  task automatic program_regs(input logic [15:0] s, input logic [15:0] b,
                              input logic [15:0] a, input logic [7:0] to);
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (bus_results_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SETUP_TICKS;
    cfg_data  <= s;
    @(posedge clk);
    cfg_index <= CFG_BIT_TICKS;
    cfg_data  <= b;
    @(posedge clk);
    cfg_index <= CFG_ACK_TICKS;
    cfg_data  <= a;
    @(posedge clk);
    cfg_index <= CFG_ACK_TIMEOUT;
    cfg_data  <= {8'd0, to};
    @(posedge clk);
    cfg_we  <= 1'b0;
    r_setup = s;
    r_bit   = b;
    r_ack   = a;
    r_tmo   = to;
  endtask

  // mostly framed bus transactions: start, one to three bytes, stop
  task automatic random_traffic(int span);
    int stop_at, nb;
    stop_at = ticks_sent + span;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(0, 99) < 80) begin
        run_cmd(rand_row(1'b1, KIND_START));
        nb = $urandom_range(1, 3);
        repeat (nb) run_cmd(rand_row(1'b1, $urandom_range(0, 1) ? KIND_WRITE : KIND_READ));
        run_cmd(rand_row(1'b1, KIND_STOP));
      end else begin
        run_cmd(rand_row(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3))));
      end
    end
  endtask

  initial begin
    res_ch.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (res_ch.valid && res_ch.ready) check_result();
        if (hold_req) begin
          hold_left = 300;
          hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
          hold_left--;
          res_ch.ready <= 1'b0;
        end else begin
          res_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    cmd_row_t c;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = CFG_SETUP_TICKS;
    cfg_data         = '0;
    cmd_ch.valid     = 1'b0;
    cmd_ch.cmd_valid = 1'b0;
    cmd_ch.kind      = KIND_START;
    cmd_ch.wr_data   = '0;
    cmd_ch.send_ack  = 1'b0;
    cmd_ch.sda_in    = 1'b1;
    hold_req         = 1'b0;
    ticks_sent       = 0;
    mismatches       = 0;
    idle_cycles      = 0;
    tx_idle_pct      = 34;
    rx_idle_pct      = 68;
    engine_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) run_cmd(dir_rows[i]);

    program_regs(16'd1, 16'd1, 16'd2, 8'd3);
    random_traffic(40);

    tx_idle_pct = 68;
    rx_idle_pct = 34;
    // zero lengths act as one; zero timeout fails on the first high poll
    program_regs(16'd0, 16'd0, 16'd0, 8'd0);
    random_traffic(40);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    program_regs(16'd3, 16'd2, 16'd1, 8'd12);
    hold_req = 1'b1;
    random_traffic(40);

    // largest timeout: 255 high polls pass, the next one fails
    program_regs(16'd1, 16'd1, 16'd1, 8'hFF);
    c = rand_row(1'b1, KIND_WRITE);
    c.highs = NEVER_ACK;
    run_cmd(c);
    c = rand_row(1'b1, KIND_WRITE);
    c.highs = 0;
    run_cmd(c);

    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (bus_results_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (bus_results_q.size() != 0) report("results never arrived", 8'h00, 8'h00);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/i2c_mbe_pkg.sv
hdl/i2c_mbe_ifs.sv
hdl/i2c_master_byte_engine_unit.sv
bench/tb.sv
